// File: rtl/onewire_register_transaction_assert.svh
// Assertion macros used by the 1-Wire register transaction core (owrt_core).
// Needs nothing else; the core includes it by name.
`ifndef ONEWIRE_REGISTER_TRANSACTION_ASSERT_SVH
`define ONEWIRE_REGISTER_TRANSACTION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OW_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("onewire assertion failed");

// Next-cycle implication, disabled during reset.
`define OW_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("onewire assertion failed");

`endif

// File: rtl/owrt_pkg.sv
// Package for the 1-Wire register transaction master: phases, function
// codes, command bytes, timing constants and the result struct. No dependencies.
package owrt_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RST_LOW = 3'd1,
    PH_RST_REL = 3'd2,
    PH_WR_LOW  = 3'd3,
    PH_WR_REL  = 3'd4,
    PH_RD_LOW  = 3'd5,
    PH_RD_WAIT = 3'd6,
    PH_RD_TAIL = 3'd7
  } ow_phase_e;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_COPY  = 2'd3;

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_READ     = 8'h69;
  localparam logic [7:0] CMD_WRITE    = 8'h6C;
  localparam logic [7:0] CMD_COPY     = 8'h48;

  localparam logic [8:0] T_RST_LOW   = 9'd480;
  localparam logic [8:0] T_RST_REL   = 9'd480;
  localparam logic [8:0] T_PRESENCE  = 9'd70;
  localparam logic [8:0] T_W1_LOW    = 9'd6;
  localparam logic [8:0] T_W1_REL    = 9'd64;
  localparam logic [8:0] T_W0_LOW    = 9'd60;
  localparam logic [8:0] T_W0_REL    = 9'd80;
  localparam logic [8:0] T_RD_LOW    = 9'd6;
  localparam logic [8:0] T_RD_SAMPLE = 9'd9;
  localparam logic [8:0] T_RD_TAIL   = 9'd55;

  localparam logic [7:0] TICKS_PER_US_RESET = 8'd8;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       present;
    logic       rejected;
  } ow_result_t;

endpackage

// File: rtl/owrt_core.sv
// Transaction engine of the 1-Wire master: holds the bus state and advances
// it by one tick per step. Depends on owrt_pkg and the assertion header.
`include "onewire_register_transaction_assert.svh"

module owrt_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          func_i,
  input  logic [7:0]          reg_addr_i,
  input  logic [7:0]          write_data_i,
  input  logic                line_in_i,
  input  logic [7:0]          ticks_per_us_i,
  output owrt_pkg::ow_result_t result_o
);

  owrt_pkg::ow_phase_e phase_q, phase_d;
  logic [2:0] byte_q, byte_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [8:0] us_q, us_d;
  logic [7:0] div_q, div_d;
  logic [1:0] op_q, op_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] value_q, value_d;
  logic       pres_q, pres_d;
  logic [7:0] last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owrt_pkg::PH_IDLE;
      byte_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      us_q    <= '0;
      div_q   <= '0;
      op_q    <= '0;
      addr_q  <= '0;
      value_q <= '0;
      pres_q  <= 1'b0;
      last_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      byte_q  <= byte_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      us_q    <= us_d;
      div_q   <= div_d;
      op_q    <= op_d;
      addr_q  <= addr_d;
      value_q <= value_d;
      pres_q  <= pres_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    logic       done;
    logic       rej;
    logic       drive;
    logic       bit_val;
    logic       slot_end;
    logic       was_write;
    logic       start_rd;
    logic [8:0] lim;

    phase_d = phase_q;
    byte_d  = byte_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    us_d    = us_q;
    div_d   = div_q;
    op_d    = op_q;
    addr_d  = addr_q;
    value_d = value_q;
    pres_d  = pres_q;
    last_d  = last_q;
    done      = 1'b0;
    rej       = 1'b0;
    slot_end  = 1'b0;
    was_write = 1'b0;
    start_rd  = 1'b0;

    if (func_i != owrt_pkg::FUNC_TICK) begin
      if (phase_q == owrt_pkg::PH_IDLE) begin
        op_d    = func_i;
        addr_d  = reg_addr_i;
        value_d = write_data_i;
        pres_d  = 1'b0;
        byte_d  = '0;
        bit_d   = '0;
        shift_d = '0;
        us_d    = '0;
        div_d   = '0;
        phase_d = owrt_pkg::PH_RST_LOW;
      end else begin
        rej = 1'b1;
      end
    end

    drive = (phase_d == owrt_pkg::PH_RST_LOW) || (phase_d == owrt_pkg::PH_WR_LOW) ||
            (phase_d == owrt_pkg::PH_RD_LOW);
    bit_val = shift_d[0];
    lim     = '0;

    if (phase_d != owrt_pkg::PH_IDLE) begin
      div_d = div_d + 8'd1;
      if ((div_d >= ticks_per_us_i) || (div_d == 8'd0)) begin
        // One microsecond has elapsed: advance the bus timing.
        div_d = '0;
        us_d  = us_d + 9'd1;
        case (phase_d)
          owrt_pkg::PH_RST_LOW: begin
            if (us_d >= owrt_pkg::T_RST_LOW) begin
              phase_d = owrt_pkg::PH_RST_REL;
              us_d    = '0;
            end
          end
          owrt_pkg::PH_RST_REL: begin
            if (us_d == owrt_pkg::T_PRESENCE) pres_d = ~line_in_i;
            if (us_d >= owrt_pkg::T_RST_REL) begin
              byte_d  = '0;
              bit_d   = '0;
              shift_d = owrt_pkg::CMD_SKIP_ROM;
              us_d    = '0;
              phase_d = owrt_pkg::PH_WR_LOW;
            end
          end
          owrt_pkg::PH_WR_LOW: begin
            lim = bit_val ? owrt_pkg::T_W1_LOW : owrt_pkg::T_W0_LOW;
            if (us_d >= lim) begin
              phase_d = owrt_pkg::PH_WR_REL;
              us_d    = '0;
            end
          end
          owrt_pkg::PH_WR_REL: begin
            lim = bit_val ? owrt_pkg::T_W1_REL : owrt_pkg::T_W0_REL;
            if (us_d >= lim) begin
              slot_end  = 1'b1;
              was_write = 1'b1;
            end
          end
          owrt_pkg::PH_RD_LOW: begin
            if (us_d >= owrt_pkg::T_RD_LOW) begin
              phase_d = owrt_pkg::PH_RD_WAIT;
              us_d    = '0;
            end
          end
          owrt_pkg::PH_RD_WAIT: begin
            if (us_d >= owrt_pkg::T_RD_SAMPLE) begin
              shift_d = {line_in_i, shift_d[7:1]};
              phase_d = owrt_pkg::PH_RD_TAIL;
              us_d    = '0;
            end
          end
          owrt_pkg::PH_RD_TAIL: begin
            if (us_d >= owrt_pkg::T_RD_TAIL) slot_end = 1'b1;
          end
          default: begin
            phase_d = owrt_pkg::PH_IDLE;
            us_d    = '0;
            div_d   = '0;
            byte_d  = '0;
            bit_d   = '0;
          end
        endcase
      end
    end

    if (slot_end) begin
      if (was_write) shift_d = {1'b0, shift_d[7:1]};
      if (bit_d < 3'd7) begin
        bit_d   = bit_d + 3'd1;
        start_rd = (op_d == owrt_pkg::FUNC_READ) && (byte_d == 3'd3);
        us_d    = '0;
        phase_d = start_rd ? owrt_pkg::PH_RD_LOW : owrt_pkg::PH_WR_LOW;
      end else begin
        bit_d  = '0;
        byte_d = byte_d + 3'd1;
        if ((byte_d >= 3'd4) ||
            ((op_d == owrt_pkg::FUNC_COPY) && (byte_d >= 3'd3))) begin
          if (op_d == owrt_pkg::FUNC_READ) last_d = shift_d;
          phase_d = owrt_pkg::PH_IDLE;
          us_d    = '0;
          div_d   = '0;
          byte_d  = '0;
          bit_d   = '0;
          done    = 1'b1;
        end else begin
          if (byte_d == 3'd1) begin
            case (op_d)
              owrt_pkg::FUNC_READ:  shift_d = owrt_pkg::CMD_READ;
              owrt_pkg::FUNC_WRITE: shift_d = owrt_pkg::CMD_WRITE;
              default:              shift_d = owrt_pkg::CMD_COPY;
            endcase
          end else if (byte_d == 3'd2) begin
            shift_d = addr_d;
          end else begin
            shift_d = (op_d == owrt_pkg::FUNC_WRITE) ? value_d : 8'h00;
          end
          start_rd = (op_d == owrt_pkg::FUNC_READ) && (byte_d == 3'd3);
          us_d     = '0;
          phase_d  = start_rd ? owrt_pkg::PH_RD_LOW : owrt_pkg::PH_WR_LOW;
        end
      end
    end

    result_o.drive_low = drive;
    result_o.busy_res  = (phase_d != owrt_pkg::PH_IDLE);
    result_o.done_res  = done;
    result_o.read_data = last_d;
    result_o.present   = pres_d;
    result_o.rejected  = rej;
  end

  // A finishing step must leave the engine idle.
  `OW_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, step_i && result_o.done_res,
                  phase_q == owrt_pkg::PH_IDLE)
  // A start request while a transaction runs is reported as rejected.
  `OW_ASSERT_IMPL(a_busy_reject, clk_i, rst_ni,
                  step_i && (phase_q != owrt_pkg::PH_IDLE) && (func_i != owrt_pkg::FUNC_TICK),
                  result_o.rejected)
  // Timers are cleared whenever the engine rests.
  `OW_ASSERT_IMPL(a_idle_clear, clk_i, rst_ni, phase_q == owrt_pkg::PH_IDLE,
                  (div_q == 8'd0) && (us_q == 9'd0) && (bit_q == 3'd0))

endmodule

// File: rtl/onewire_register_transaction.sv
// Dataflow: an accepted tick is held in the input register, the core computes its result
// from there in the step, and the result is registered in the output register for transfer.
// Throughput: one tick per cycle, as the engine finishes a tick in one step; a waiting result
// stalls the input only once the input register also holds a tick.
// Reset (rst_ni, asynchronous, active low): engine idle, engine state zero, ticks_per_us 8,
// no result pending. Top level; depends on owrt_pkg and owrt_core.
module onewire_register_transaction (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] write_data_i,
  input  logic       line_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       drive_low_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] read_data_o,
  output logic       present_o,
  output logic       rejected_o
);

  logic [7:0] tpu_q;
  logic       s1_valid_q;
  logic [1:0] s1_func_q;
  logic [7:0] s1_addr_q;
  logic [7:0] s1_data_q;
  logic       s1_line_q;
  logic       out_valid_q;
  owrt_pkg::ow_result_t res;
  owrt_pkg::ow_result_t out_q;
  logic       advance;
  logic       in_take;
  logic       step;

  assign advance    = ~out_valid_q | out_ready_i;
  assign in_ready_o = ~s1_valid_q | advance;
  assign in_take    = in_valid_i & in_ready_o;
  assign step       = s1_valid_q & advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q       <= owrt_pkg::TICKS_PER_US_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) tpu_q <= cfg_wdata_i;
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_func_q <= func_i;
      s1_addr_q <= reg_addr_i;
      s1_data_q <= write_data_i;
      s1_line_q <= line_in_i;
    end
    if (step) out_q <= res;
  end

  owrt_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .func_i         (s1_func_q),
    .reg_addr_i     (s1_addr_q),
    .write_data_i   (s1_data_q),
    .line_in_i      (s1_line_q),
    .ticks_per_us_i (tpu_q),
    .result_o       (res)
  );

  assign out_valid_o = out_valid_q;
  assign drive_low_o = out_q.drive_low;
  assign busy_res_o  = out_q.busy_res;
  assign done_res_o  = out_q.done_res;
  assign read_data_o = out_q.read_data;
  assign present_o   = out_q.present;
  assign rejected_o  = out_q.rejected;

endmodule
